FILE: hdl/burq_pkg.sv
package burq_pkg;

	// event codes on the input channel
	localparam logic [2:0] ACT_LINE_RX  = 3'd0;
	localparam logic [2:0] ACT_TX_READY = 3'd1;
	localparam logic [2:0] ACT_SW_SEND  = 3'd2;
	localparam logic [2:0] ACT_SW_RECV  = 3'd3;
	localparam logic [2:0] ACT_CLEAR_RX = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_in;
		logic       line_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       to_line;
		logic       status;
		logic       rx_irq_on;
		logic       tx_irq_on;
		logic       tx_pending;
		logic       rx_pending;
	} out_item_t;

	// source of the popped byte
	typedef enum logic [1:0] {
		DSEL_ZERO,
		DSEL_RX,
		DSEL_TX
	} dsel_t;

	// controller to datapath
	typedef struct packed {
		logic start;
	} cmd_t;

endpackage

FILE: hdl/burq_in_if.sv
interface burq_in_if;
	import burq_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/burq_out_if.sv
interface burq_out_if;
	import burq_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/burq_ctrl.sv
module burq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output burq_pkg::cmd_t   cmd
);
	import burq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_BUSY);
	assign cmd.start = in_valid && (state_q == ST_IDLE);
endmodule

FILE: hdl/burq_dpath.sv
module burq_dpath #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  burq_pkg::cmd_t      cmd,
	input  burq_pkg::in_item_t  in_item,
	output burq_pkg::out_item_t out_item
);
	import burq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [7:0] rx_mem [QUEUE_DEPTH];
	logic [7:0] tx_mem [QUEUE_DEPTH];

	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic             rx_en_q, tx_en_q;
	logic             line_q, refused_q;
	dsel_t            dsel_q;
	logic [7:0]       rx_rd_q, tx_rd_q;

	logic [PTR_W-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic             rx_en_d, tx_en_d, line_d, refused_d;
	logic             rx_we, tx_we;
	dsel_t            dsel_d;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		advance = (p == LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		rx_en_d   = rx_en_q;
		tx_en_d   = tx_en_q;
		line_d    = 1'b0;
		refused_d = 1'b0;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		dsel_d    = DSEL_ZERO;
		unique case (in_item.action)
			ACT_LINE_RX: begin
				if (!in_item.line_error) begin
					if (advance(rx_tail_q) == rx_head_q) begin
						refused_d = 1'b1;
						rx_en_d   = 1'b0;
					end else begin
						rx_we     = 1'b1;
						rx_tail_d = advance(rx_tail_q);
					end
				end
			end
			ACT_TX_READY: begin
				if (tx_head_q == tx_tail_q) begin
					refused_d = 1'b1;
					tx_en_d   = 1'b0;
				end else begin
					line_d    = 1'b1;
					dsel_d    = DSEL_TX;
					tx_head_d = advance(tx_head_q);
				end
			end
			ACT_SW_SEND: begin
				tx_en_d = 1'b1;
				if (advance(tx_tail_q) == tx_head_q) begin
					refused_d = 1'b1;
				end else begin
					tx_we     = 1'b1;
					tx_tail_d = advance(tx_tail_q);
				end
			end
			ACT_SW_RECV: begin
				rx_en_d = 1'b1;
				if (rx_head_q == rx_tail_q) begin
					refused_d = 1'b1;
				end else begin
					dsel_d    = DSEL_RX;
					rx_head_d = advance(rx_head_q);
				end
			end
			ACT_CLEAR_RX: begin
				rx_head_d = rx_tail_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			rx_en_q   <= 1'b1;
			tx_en_q   <= 1'b0;
			line_q    <= 1'b0;
			refused_q <= 1'b0;
			dsel_q    <= DSEL_ZERO;
		end else if (cmd.start) begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			rx_en_q   <= rx_en_d;
			tx_en_q   <= tx_en_d;
			line_q    <= line_d;
			refused_q <= refused_d;
			dsel_q    <= dsel_d;
		end
	end

	// queue stores, read at the head on every start
	always_ff @(posedge clk) begin
		if (rx_we && cmd.start) begin
			rx_mem[rx_tail_q] <= in_item.data_in;
		end
		if (cmd.start) begin
			rx_rd_q <= rx_mem[rx_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we && cmd.start) begin
			tx_mem[tx_tail_q] <= in_item.data_in;
		end
		if (cmd.start) begin
			tx_rd_q <= tx_mem[tx_head_q];
		end
	end

	always_comb begin
		unique case (dsel_q)
			DSEL_RX: out_item.data_out = rx_rd_q;
			DSEL_TX: out_item.data_out = tx_rd_q;
			default: out_item.data_out = 8'd0;
		endcase
	end

	assign out_item.to_line    = line_q;
	assign out_item.status     = refused_q;
	assign out_item.rx_irq_on  = rx_en_q;
	assign out_item.tx_irq_on  = tx_en_q;
	assign out_item.tx_pending = (tx_head_q != tx_tail_q);
	assign out_item.rx_pending = (rx_head_q != rx_tail_q);
endmodule

FILE: hdl/buffered_uart_ring_queues.sv
// channel  | dir | payload                                              | transfer when
// ---------+-----+------------------------------------------------------+---------------
// in_ch    | in  | action, data_in, line_error                          | valid && ready
// out_ch   | out | data_out, to_line, status, rx/tx_irq_on, tx/rx_pend. | valid && ready
//
// one event at a time: an event is taken in the idle state, its result is shown
// from the next cycle on, and the controller takes no new event while a result is held
// arst_n clears both queues, sets the receive interrupt enable, clears the send one
// a stalled result holds out_ch.valid and its payload; in_ch.ready stays low until taken
module buffered_uart_ring_queues #(
	parameter int QUEUE_DEPTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	burq_in_if.sink   in_ch,
	burq_out_if.source out_ch
);
	import burq_pkg::*;

	cmd_t cmd;

	// sequencer: idle, then hold the result until the sink takes it
	burq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// pointers, interrupt enables and both byte stores
	burq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_ch.item),
		.out_item (out_ch.item)
	);
endmodule

FILE: bench/tb_ring_pkg.sv
`timescale 1ns / 100ps

package tb_ring_pkg;
	import burq_pkg::*;

	localparam int RING_SLOTS = 64;

	// codes the block treats as no-ops
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	class uart_queue_mirror;
		logic [7:0]  rx_ring [RING_SLOTS];
		logic [7:0]  tx_ring [RING_SLOTS];
		int unsigned rx_rd, rx_wr, tx_rd, tx_wr;
		bit          rx_ie, tx_ie;
		out_item_t   expected_replies [$];
		int unsigned failures;

		function new();
			rx_rd = 0;
			rx_wr = 0;
			tx_rd = 0;
			tx_wr = 0;
			rx_ie = 1'b1;
			tx_ie = 1'b0;
			failures = 0;
		endfunction

		// mirror one accepted event and queue the reply it must produce
		function void note_event(in_item_t ev);
			out_item_t   reply;
			int unsigned nxt;
			reply = '0;
			case (ev.action)
				ACT_LINE_RX: begin
					if (!ev.line_error) begin
						nxt = (rx_wr + 1) % RING_SLOTS;
						if (nxt == rx_rd) begin
							reply.status = 1'b1;
							rx_ie = 1'b0;
						end else begin
							rx_ring[rx_wr] = ev.data_in;
							rx_wr = nxt;
						end
					end
				end
				ACT_TX_READY: begin
					if (tx_rd == tx_wr) begin
						reply.status = 1'b1;
						tx_ie = 1'b0;
					end else begin
						reply.data_out = tx_ring[tx_rd];
						reply.to_line = 1'b1;
						tx_rd = (tx_rd + 1) % RING_SLOTS;
					end
				end
				ACT_SW_SEND: begin
					nxt = (tx_wr + 1) % RING_SLOTS;
					if (nxt == tx_rd) begin
						reply.status = 1'b1;
					end else begin
						tx_ring[tx_wr] = ev.data_in;
						tx_wr = nxt;
					end
					tx_ie = 1'b1;
				end
				ACT_SW_RECV: begin
					if (rx_rd == rx_wr) begin
						reply.status = 1'b1;
					end else begin
						reply.data_out = rx_ring[rx_rd];
						rx_rd = (rx_rd + 1) % RING_SLOTS;
					end
					rx_ie = 1'b1;
				end
				ACT_CLEAR_RX: begin
					rx_rd = rx_wr;
				end
				default: begin
				end
			endcase
			reply.rx_irq_on  = rx_ie;
			reply.tx_irq_on  = tx_ie;
			reply.tx_pending = (tx_rd != tx_wr);
			reply.rx_pending = (rx_rd != rx_wr);
			expected_replies.push_back(reply);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				$error("%s: expected 0x%02h, got 0x%02h", name, want, seen);
				failures++;
			end
		endfunction

		function void check_reply(out_item_t got);
			out_item_t want;
			if (expected_replies.size() == 0) begin
				$error("result with nothing pending: data_out 0x%02h status %b",
					got.data_out, got.status);
				failures++;
				return;
			end
			want = expected_replies.pop_front();
			compare_field("data_out", want.data_out, got.data_out);
			compare_field("to_line", 8'(want.to_line), 8'(got.to_line));
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("rx_irq_on", 8'(want.rx_irq_on), 8'(got.rx_irq_on));
			compare_field("tx_irq_on", 8'(want.tx_irq_on), 8'(got.tx_irq_on));
			compare_field("tx_pending", 8'(want.tx_pending), 8'(got.tx_pending));
			compare_field("rx_pending", 8'(want.rx_pending), 8'(got.rx_pending));
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import burq_pkg::*;
	import tb_ring_pkg::*;

	// cycles with no transfer on either channel before the run is declared hung
	localparam int STALL_LIMIT = 1000;
	// rough count of meaningful events for the random phase
	localparam int EVENT_GOAL = 650;

	logic clk;
	logic arst_n;

	burq_in_if  in_ch ();
	burq_out_if out_ch ();

	buffered_uart_ring_queues #(
		.QUEUE_DEPTH(RING_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	uart_queue_mirror queue_mirror;

	int burst_left;
	int real_events;

	// free-running clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic in_item_t make_event(logic [2:0] act, logic [7:0] data, logic err);
		in_item_t ev;
		ev.action     = act;
		ev.data_in    = data;
		ev.line_error = err;
		return ev;
	endfunction

	// drop valid, one assignment per falling edge
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
	endtask

	// offer one event and hold it until the transfer happens
	// the sender works in bursts; a gap may open before a new burst starts
	task automatic offer(in_item_t ev);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// about one burst in four starts with no gap at all
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 8));
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.item  <= ev;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		queue_mirror.note_event(ev);
		// error bytes and unused codes do not move the event count
		if (ev.action <= ACT_CLEAR_RX && !(ev.action == ACT_LINE_RX && ev.line_error))
			real_events++;
	endtask

	// sender pause: nothing offered until every reply has come back
	task automatic wait_drained();
		idle_cycles(1);
		while (queue_mirror.pending() != 0)
			@(posedge clk);
	endtask

	// a run of one event kind with random bytes; err_odds of n gives a line error
	// roughly once in n events
	task automatic offer_run(logic [2:0] act, int n, int err_odds);
		repeat (n)
			offer(make_event(act, 8'($urandom_range(0, 255)), $urandom_range(1, err_odds) == 1));
	endtask

	// one random segment: mostly well-formed fill and drain runs so that both
	// rings reach full and empty, plus mixed traffic and a little noise
	task automatic random_segment();
		case ($urandom_range(0, 9))
			0, 1: offer_run(ACT_LINE_RX, $urandom_range(40, 80), 16);
			2: offer_run(ACT_SW_RECV, $urandom_range(10, 70), 8);
			3, 4: offer_run(ACT_SW_SEND, $urandom_range(40, 80), 8);
			5: offer_run(ACT_TX_READY, $urandom_range(10, 70), 8);
			6: begin
				offer_run(ACT_CLEAR_RX, 1, 2);
				offer_run(ACT_SW_RECV, $urandom_range(1, 4), 2);
			end
			7, 8: begin
				repeat ($urandom_range(5, 30))
					offer(make_event(3'($urandom_range(ACT_LINE_RX, ACT_CLEAR_RX)),
						8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
			end
			default: begin
				// noise: any code, including the unused ones, any error flag
				repeat ($urandom_range(1, 6))
					offer(make_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1))));
			end
		endcase
	endtask

	// directed events: field extremes, every action, refusals on empty rings
	task automatic directed_phase();
		int a;
		// pops on empty rings: software receive sets rx enable, tx ready clears tx enable
		offer(make_event(ACT_SW_RECV, 8'h00, 1'b0));
		offer(make_event(ACT_TX_READY, 8'hff, 1'b0));
		// line byte with an error flag is dropped
		offer(make_event(ACT_LINE_RX, 8'hff, 1'b1));
		offer(make_event(ACT_LINE_RX, 8'h00, 1'b0));
		offer(make_event(ACT_LINE_RX, 8'hff, 1'b0));
		offer(make_event(ACT_LINE_RX, 8'ha5, 1'b0));
		offer(make_event(ACT_SW_RECV, 8'hff, 1'b1));
		offer(make_event(ACT_SW_RECV, 8'h00, 1'b0));
		offer(make_event(ACT_SW_RECV, 8'h00, 1'b0));
		offer(make_event(ACT_SW_RECV, 8'h00, 1'b0));
		offer(make_event(ACT_SW_SEND, 8'h00, 1'b0));
		offer(make_event(ACT_SW_SEND, 8'hff, 1'b1));
		offer(make_event(ACT_TX_READY, 8'h00, 1'b0));
		offer(make_event(ACT_TX_READY, 8'h00, 1'b1));
		offer(make_event(ACT_TX_READY, 8'h00, 1'b0));
		// clear with bytes waiting, then a receive that finds the ring empty
		offer(make_event(ACT_LINE_RX, 8'h3c, 1'b0));
		offer(make_event(ACT_LINE_RX, 8'hc3, 1'b0));
		offer(make_event(ACT_CLEAR_RX, 8'hff, 1'b1));
		offer(make_event(ACT_SW_RECV, 8'h00, 1'b0));
		// clear on an empty ring
		offer(make_event(ACT_CLEAR_RX, 8'h00, 1'b0));
		// unused codes change nothing
		for (a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
			offer(make_event(3'(a), 8'hff, 1'b1));
		offer(make_event(ACT_SW_SEND, 8'h5a, 1'b1));
		offer(make_event(ACT_TX_READY, 8'h00, 1'b0));
	endtask

	// main sequence: reset once, directed events, random segments, drain, verdict
	initial begin
		queue_mirror = new();
		burst_left   = 0;
		real_events  = 0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.item   = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_phase();
		// first sender pause, guaranteed once
		wait_drained();

		real_events = 0;
		while (real_events < EVENT_GOAL) begin
			random_segment();
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		// all stimulus is in: let the replies come home, then keep watching
		// to catch anything extra the block might still send
		idle_cycles(1);
		while (queue_mirror.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (queue_mirror.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: runs of ready and short stalls of its own, with a long hold-off
	// now and then so the block holds its result and stalls its input while events are offered
	initial begin
		int round;
		int n_on;
		int n_off;
		round = 0;
		@(posedge arst_n);
		forever begin
			round++;
			if (round % 16 == 3) begin
				n_on  = 1;
				n_off = $urandom_range(40, 60);
			end else begin
				n_on  = $urandom_range(1, 20);
				// a third of the rounds run with no stall
				n_off = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
			repeat (n_on) begin
				@(negedge clk);
				out_ch.ready <= 1'b1;
			end
			repeat (n_off) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
		end
	end

	// result monitor: every transfer on the output is checked against the oldest
	// expectation
	initial begin
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				queue_mirror.check_reply(out_ch.item);
		end
	end

	// watchdog: counts cycles with no transfer on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transfer for %0d cycles, %0d results still pending",
			STALL_LIMIT, queue_mirror.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
